// File: rtl/core/mpt_pkg.sv
// Shared constants and types for the Mandelbrot point test block.
package mpt_pkg;

  localparam int unsigned DefMaxSide  = 4096;
  localparam int unsigned DefIterBits = 16;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned GSIDE_W = 13;
  localparam int unsigned MAXIT_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned FRAC_W  = 28;
  localparam int unsigned PROD_W  = 2 * Q_W;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic {
    REG_GRID_SIDE = 1'b0,
    REG_MAX_ITER  = 1'b1
  } reg_idx_e;

  localparam logic [GSIDE_W-1:0] GRID_SIDE_RST = GSIDE_W'(1024);
  localparam logic [MAXIT_W-1:0] MAX_ITER_RST  = MAXIT_W'(1000);

  // |z|^2 limit of 4 in Q8.56
  localparam logic [PROD_W-1:0] ESCAPE_LIM = PROD_W'(64'd4 << (2 * FRAC_W));

  typedef struct packed {
    logic ld_re;
    logic ld_im;
    logic mul;
    logic step;
  } zs_ctrl_t;

endpackage

// File: rtl/core/mandelbrot_point_test.sv
// Mandelbrot escape-time membership test for one grid point per request.
//
// Input stream: s_axis_tdata carries column and row of a grid point. The
// block takes one request at a time; s_axis_tready is high only while idle.
// Output stream: one result per request, with the in-set flag and the
// saturating count of in-set points since reset, including this point.
// Configuration: cfg_we_i writes grid_side (index 0) or max_iterations
// (index 1); write only while no request is in flight.
//
// Sequence: each coordinate goes through a one-bit-per-cycle divider, the
// column for the real part and then the row for the imaginary part. Then
// each iteration runs on the complex multiplier as products, then update
// and escape test.
// The result sits in an output register, so a stalled receiver does not
// hold off the next request; a second result waits until the first leaves.
// Reset restores grid_side 1024, max_iterations 1000 and a zero total.
module mandelbrot_point_test #(
  parameter int unsigned MAX_SIDE  = mpt_pkg::DefMaxSide,
  parameter int unsigned ITER_BITS = mpt_pkg::DefIterBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mpt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // column, row
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mpt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // in_set, points_in_set
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [mpt_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W  = (SIDE_W > mpt_pkg::GSIDE_W) ? SIDE_W : mpt_pkg::GSIDE_W;
  localparam int unsigned TW     = mpt_pkg::TOTAL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [mpt_pkg::GSIDE_W-1:0]     grid_side_q;
  logic [mpt_pkg::MAXIT_W-1:0]     max_iter_q;
  logic [mpt_pkg::COORD_W-1:0]     row_q;
  logic [ITER_BITS-1:0]            n_q;
  logic                            in_set_q;
  logic [TW-1:0]                   total_q;
  logic                            m_valid_q;
  logic                            m_in_set_q;
  logic [TW-1:0]                   m_total_q;

  logic                            accept;
  logic [CMP_W-1:0]                gs_ext;
  logic [SIDE_W-1:0]               side_eff;
  logic [ITER_BITS-1:0]            iter_lim;
  logic                            div_start, div_done;
  logic [mpt_pkg::COORD_W-1:0]     div_coord;
  logic signed [mpt_pkg::Q_W-1:0]  div_c;
  logic                            escape, esc_hit, lim_hit, out_free, out_load;
  logic [TW-1:0]                   total_nxt;
  mpt_pkg::zs_ctrl_t               zs_ctrl;

  assign gs_ext   = CMP_W'(grid_side_q);
  assign side_eff = (gs_ext == '0) ? SIDE_W'(1) :
                    (gs_ext > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : gs_ext[SIDE_W-1:0];
  assign iter_lim = ITER_BITS'(max_iter_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign div_start = (state_q == ST_IDLE) ? accept : ((state_q == ST_MAP_RE) && div_done);
  assign div_coord = (state_q == ST_IDLE) ? s_axis_tdata[mpt_pkg::COORD_W-1:0] : row_q;

  assign esc_hit  = (n_q != '0) && escape;
  assign lim_hit  = (n_q == iter_lim);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_FIN) && out_free;

  assign zs_ctrl.ld_re = (state_q == ST_MAP_RE) && div_done;
  assign zs_ctrl.ld_im = (state_q == ST_MAP_IM) && div_done;
  assign zs_ctrl.mul   = (state_q == ST_MUL);
  assign zs_ctrl.step  = (state_q == ST_UPD) && !esc_hit && !lim_hit;

  assign total_nxt = (in_set_q && (total_q != '1)) ? total_q + TW'(1) : total_q;

  mpt_map_div #(
    .MAX_SIDE (MAX_SIDE)
  ) u_map_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .coord_i (div_coord),
    .side_i  (side_eff),
    .done_o  (div_done),
    .c_o     (div_c)
  );

  mpt_zstep u_zstep (
    .clk_i    (clk_i),
    .ctrl_i   (zs_ctrl),
    .c_i      (div_c),
    .escape_o (escape)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= mpt_pkg::GRID_SIDE_RST;
      max_iter_q  <= mpt_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (mpt_pkg::reg_idx_e'(cfg_idx_i))
        mpt_pkg::REG_GRID_SIDE: grid_side_q <= cfg_data_i[mpt_pkg::GSIDE_W-1:0];
        mpt_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_data_i[mpt_pkg::MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      n_q        <= '0;
      in_set_q   <= 1'b0;
      total_q    <= '0;
      m_valid_q  <= 1'b0;
      m_in_set_q <= 1'b0;
      m_total_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            row_q   <= s_axis_tdata[2*mpt_pkg::COORD_W-1:mpt_pkg::COORD_W];
            state_q <= ST_MAP_RE;
          end
        end
        ST_MAP_RE: begin
          if (div_done) state_q <= ST_MAP_IM;
        end
        ST_MAP_IM: begin
          if (div_done) begin
            n_q     <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_UPD;
        ST_UPD: begin
          priority if (esc_hit) begin
            in_set_q <= 1'b0;
            state_q  <= ST_FIN;
          end else if (lim_hit) begin
            in_set_q <= 1'b1;
            state_q  <= ST_FIN;
          end else begin
            n_q     <= n_q + ITER_BITS'(1);
            state_q <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_in_set_q <= in_set_q;
            m_total_q  <= total_nxt;
            total_q    <= total_nxt;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(mpt_pkg::OUT_TDATA_W - TW - 1){1'b0}}, m_total_q, m_in_set_q};

endmodule

// File: rtl/core/mpt_map_div.sv
// Serial restoring divider that maps a grid coordinate to a Q4.28 value of c.
module mpt_map_div #(
  parameter int unsigned MAX_SIDE = mpt_pkg::DefMaxSide
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [mpt_pkg::COORD_W-1:0]               coord_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]             side_i,
  output logic                                      done_o,
  output logic signed [mpt_pkg::Q_W-1:0]            c_o
);

  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW     = (SIDE_W + 1 > mpt_pkg::COORD_W + 2) ?
                                   SIDE_W + 1 : mpt_pkg::COORD_W + 2;
  localparam int unsigned DW     = AW + 1;
  localparam int unsigned NW     = AW + mpt_pkg::FRAC_W;
  localparam int unsigned CNT_W  = $clog2(NW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SAT
  } state_e;

  state_e                state_q;
  logic [NW-1:0]         num_q;
  logic [SIDE_W-1:0]     rem_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;
  logic [mpt_pkg::Q_W-1:0] c_q;

  logic [DW-1:0]     four_c, two_s, diff, mag;
  logic [SIDE_W:0]   trial, side_ext;
  logic              ge;
  logic              pos_ovf, neg_ovf;
  logic [mpt_pkg::Q_W-1:0] q_neg;

  assign four_c   = DW'({coord_i, 2'b00});
  assign two_s    = DW'({side_i, 1'b0});
  assign diff     = four_c - two_s;
  assign mag      = diff[DW-1] ? (~diff + DW'(1)) : diff;

  assign trial    = {rem_q, num_q[NW-1]};
  assign side_ext = {1'b0, side_i};
  assign ge       = (trial >= side_ext);

  assign pos_ovf  = |num_q[NW-1:mpt_pkg::Q_W-1];
  assign neg_ovf  = (|num_q[NW-1:mpt_pkg::Q_W]) ||
                    (num_q[mpt_pkg::Q_W-1] && (|num_q[mpt_pkg::Q_W-2:0]));
  assign q_neg    = ~num_q[mpt_pkg::Q_W-1:0] + mpt_pkg::Q_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= '0;
      rem_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      c_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            num_q   <= {mag[AW-1:0], {mpt_pkg::FRAC_W{1'b0}}};
            rem_q   <= '0;
            neg_q   <= diff[DW-1];
            cnt_q   <= CNT_W'(NW - 1);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_q <= ge ? SIDE_W'(trial - side_ext) : trial[SIDE_W-1:0];
          num_q <= {num_q[NW-2:0], ge};
          if (cnt_q == '0) begin
            state_q <= ST_SAT;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_SAT: begin
          if (neg_q) begin
            c_q <= neg_ovf ? {1'b1, {(mpt_pkg::Q_W-1){1'b0}}} : q_neg;
          end else begin
            c_q <= pos_ovf ? {1'b0, {(mpt_pkg::Q_W-1){1'b1}}} : num_q[mpt_pkg::Q_W-1:0];
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign c_o    = signed'(c_q);

endmodule

// File: rtl/core/mpt_zstep.sv
// Complex square-and-add unit: registered products of z, then z = z*z + c.
module mpt_zstep (
  input  logic                           clk_i,
  input  mpt_pkg::zs_ctrl_t              ctrl_i,
  input  logic signed [mpt_pkg::Q_W-1:0] c_i,
  output logic                           escape_o
);

  localparam int unsigned QW   = mpt_pkg::Q_W;
  localparam int unsigned PW   = mpt_pkg::PROD_W;
  localparam int unsigned SUMW = PW - mpt_pkg::FRAC_W + 2;

  logic signed [QW-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q;

  logic signed [PW-1:0]   diff;
  logic signed [SUMW-1:0] sum_re, sum_im;
  logic [PW-1:0]          mag2;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi, lo;
    hi = SUMW'({1'b0, {(QW-1){1'b1}}});
    lo = -hi - SUMW'(1);
    if (v > hi) begin
      return hi[QW-1:0];
    end else if (v < lo) begin
      return lo[QW-1:0];
    end
    return v[QW-1:0];
  endfunction

  assign diff   = p_rr_q - p_ii_q;
  // floor by 2^28 for the real part, by 2^27 (doubling) for the imaginary part
  assign sum_re = SUMW'($signed(diff[PW-1:mpt_pkg::FRAC_W])) + SUMW'(cr_q);
  assign sum_im = SUMW'($signed(p_ri_q[PW-1:mpt_pkg::FRAC_W-1])) + SUMW'(ci_q);
  assign mag2   = p_rr_q + p_ii_q;

  assign escape_o = (mag2 > mpt_pkg::ESCAPE_LIM);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_re) begin
      cr_q <= c_i;
      zr_q <= c_i;
    end
    if (ctrl_i.ld_im) begin
      ci_q <= c_i;
      zi_q <= c_i;
    end
    if (ctrl_i.mul) begin
      p_rr_q <= zr_q * zr_q;
      p_ii_q <= zi_q * zi_q;
      p_ri_q <= zr_q * zi_q;
    end
    if (ctrl_i.step) begin
      zr_q <= sat_q(sum_re);
      zi_q <= sat_q(sum_im);
    end
  end

endmodule

// File: tb/mpt_orbit_checker.sv
// Checker for the Mandelbrot point test: tracks settings, predicts each result and compares.
module mpt_orbit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [mpt_pkg::IN_TDATA_W-1:0]   in_data_i,   // column, row
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [mpt_pkg::OUT_TDATA_W-1:0]  out_data_i,  // in_set, points_in_set
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [mpt_pkg::CFG_W-1:0]        cfg_data_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               results_o,
  output int                               members_o
);
  import mpt_pkg::*;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef struct packed {
    logic               in_set;
    logic [TOTAL_W-1:0] total;
  } verdict_t;

  verdict_t           expected_verdicts[$];
  logic [GSIDE_W-1:0] side_q;
  logic [MAXIT_W-1:0] iters_q;
  logic [TOTAL_W-1:0] in_set_total;

  function automatic longint clamp_q(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint coord_to_q(logic [COORD_W-1:0] coord, longint side);
    longint num;
    num = (4 * longint'(coord) - 2 * side) * (64'sd1 <<< FRAC_W);
    return clamp_q(num / side);
  endfunction

  function automatic logic point_stays_bounded(logic [IN_TDATA_W-1:0] req,
                                               logic [GSIDE_W-1:0] side_cfg,
                                               logic [MAXIT_W-1:0] iters);
    longint            side, cr, ci, zr, zi, re, im;
    logic [PROD_W-1:0] mag;
    int unsigned       k;
    side = side_cfg;
    if (side == 0) side = 1;
    if (side > DefMaxSide) side = DefMaxSide;
    cr = coord_to_q(req[COORD_W-1:0], side);
    ci = coord_to_q(req[2*COORD_W-1:COORD_W], side);
    zr = cr;
    zi = ci;
    for (k = 0; k < iters; k++) begin
      re = (zr * zr - zi * zi) >>> FRAC_W;
      im = (zr * zi) >>> (FRAC_W - 1);
      zr = clamp_q(re + cr);
      zi = clamp_q(im + ci);
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > ESCAPE_LIM) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t predicted, oldest, seen;
    int       fails;
    if (!rst_ni) begin
      side_q       <= GRID_SIDE_RST;
      iters_q      <= MAX_ITER_RST;
      in_set_total <= '0;
      expected_verdicts.delete();
      errors_o     <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      members_o    <= 0;
    end else begin
      fails = 0;
      if (cfg_we_i) begin
        if (reg_idx_e'(cfg_idx_i) == REG_GRID_SIDE) side_q <= cfg_data_i[GSIDE_W-1:0];
        else iters_q <= cfg_data_i[MAXIT_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        seen.in_set = out_data_i[0];
        seen.total  = out_data_i[TOTAL_W:1];
        results_o <= results_o + 1;
        members_o <= members_o + int'(seen.in_set);
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected: in_set %0b, total %0d",
                   $time, seen.in_set, seen.total);
          fails++;
        end else begin
          oldest = expected_verdicts.pop_front();
          if (seen.in_set !== oldest.in_set) begin
            $display("%0t: in_set expected %0b, got %0b", $time, oldest.in_set, seen.in_set);
            fails++;
          end
          if (seen.total !== oldest.total) begin
            $display("%0t: points_in_set expected %0d, got %0d",
                     $time, oldest.total, seen.total);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted.in_set = point_stays_bounded(in_data_i, side_q, iters_q);
        predicted.total  = in_set_total;
        if (predicted.in_set && in_set_total != '1) predicted.total = in_set_total + 1;
        in_set_total <= predicted.total;
        expected_verdicts.push_back(predicted);
      end
      errors_o  <= errors_o + fails;
      pending_o <= expected_verdicts.size();
    end
  end

endmodule

// File: tb/tb_mandelbrot_point_test.sv
// Testbench top for the Mandelbrot point test: drives points and settings, gives the verdict.
module tb_mandelbrot_point_test;
  import mpt_pkg::*;

  localparam int unsigned RunLimit    = 3_000_000;
  localparam int unsigned SweepCount  = 14;
  localparam int unsigned SweepPoints = 42;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // column, row
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // in_set, points_in_set
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_idx_i     = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  int                 errors_w, pending_w, results_w, members_w;
  int                 send_idle_pct = 0;
  int                 rcv_stall_pct = 0;
  int                 hold_cycles   = 0;
  int                 points_sent   = 0;
  int                 settings_used = 0;
  int unsigned        cycle_count   = 0;
  logic [GSIDE_W-1:0] cur_side      = GRID_SIDE_RST;

  always #1 clk_i = ~clk_i;

  mandelbrot_point_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  mpt_orbit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors_w),
    .pending_o   (pending_w),
    .results_o   (results_w),
    .members_o   (members_w)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("tb_mandelbrot_point_test: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_point(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    points_sent++;
  endtask

  // drain all outstanding requests, then write both registers
  task automatic apply_setting(logic [CFG_W-1:0] side, logic [CFG_W-1:0] iters);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_w != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_GRID_SIDE;
    cfg_data_i <= side;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_ITER;
    cfg_data_i <= iters;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_side = side[GSIDE_W-1:0];
    settings_used++;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned s;
    s = (cur_side == 0) ? 1 : (cur_side > DefMaxSide) ? DefMaxSide : cur_side;
    case ($urandom_range(0, 9))
      0, 1:       return COORD_W'($urandom());
      2, 3, 4, 5: return COORD_W'($urandom_range(0, s - 1));
      default:    return COORD_W'($urandom_range(s / 4, (3 * s) / 4));
    endcase
  endfunction

  initial begin
    int unsigned      sweep, n;
    logic [CFG_W-1:0] side_v, iter_v;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: origin, corner, saturated corner
    send_point(512, 512);
    send_point(0, 0);
    send_point(4095, 4095);
    // side zero acts as one, zero iterations: always in set
    apply_setting(0, 0);
    send_point(0, 0);
    send_point(4095, 4095);
    send_point(1, 2);
    // full side, longest run; c = -2 sits exactly on the radius
    apply_setting(4096, 65535);
    send_point(0, 2048);
    send_point(4095, 0);
    send_point(2048, 0);
    // side above max clamps; saturating z
    apply_setting(8191, 1);
    send_point(4095, 4095);
    send_point(4095, 2048);
    send_point(2048, 2048);
    send_point(4095, 0);
    apply_setting(1, 1);
    send_point(4095, 0);
    send_point(0, 4095);
    send_point(1, 1);
    // odd side, truncating map
    apply_setting(3, 20);
    send_point(0, 1);
    send_point(1, 2);
    send_point(2, 0);
    send_point(3, 3);

    for (sweep = 0; sweep < SweepCount; sweep++) begin
      case ($urandom_range(0, 9))
        0:       side_v = 0;
        1:       side_v = 1;
        2:       side_v = DefMaxSide;
        3:       side_v = CFG_W'($urandom_range(DefMaxSide + 1, 8191));
        4:       side_v = CFG_W'($urandom_range(2, 16));
        default: side_v = CFG_W'($urandom_range(17, DefMaxSide));
      endcase
      case ($urandom_range(0, 9))
        0:       iter_v = 0;
        1:       iter_v = 1;
        2:       iter_v = CFG_W'($urandom_range(100, 400));
        default: iter_v = CFG_W'($urandom_range(2, 64));
      endcase
      if (sweep == 2) iter_v = 8;
      apply_setting(side_v, iter_v);
      case (sweep % 4)
        0: begin
          send_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 73;
          rcv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rcv_stall_pct = 73;
        end
        default: begin
          send_idle_pct = 28;
          rcv_stall_pct = 28;
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (sweep == 2) hold_cycles = 700;
      for (n = 0; n < SweepPoints; n++) send_point(pick_coord(), pick_coord());
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_w != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d points under %0d register settings (sides 0..8191, iterations 0..65535).",
             points_sent, settings_used);
    $display("Checked %0d results, %0d of them inside the set.", results_w, members_w);
    if (errors_w == 0 && pending_w == 0) begin
      $display("tb_mandelbrot_point_test: clean");
    end else begin
      $display("tb_mandelbrot_point_test: errors");
    end
    $finish;
  end

endmodule
